>>> src/ftfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftfl_pkg: shared types and constants for the five-tuple flow log table
// entry layout, table sizing, operation and status codes, sequencer states
// ----------------------------------------------------------------------------
package ftfl_pkg;

    localparam int LOG_DEPTH = 256;
    localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    // width that holds both the entry count and the 8-bit read index
    localparam int WIDE_W    = (CNT_W > 9) ? CNT_W : 9;

    typedef enum logic [1:0] {
        OP_LOG   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_ALT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_HIT      = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ_OK  = 3'd3,
        ST_READ_OOR = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT_WR,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]        src_addr;
        logic [31:0]        dst_addr;
        logic [31:0]        ports;     // source port high, destination port low
        logic [7:0]         proto;
        logic [7:0]         verdict;
        logic signed [31:0] cause;
        logic [31:0]        stamp;
        logic [31:0]        hits;
    } entry_t;

endpackage
`default_nettype wire

>>> src/five_tuple_flow_log_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_tuple_flow_log_table_core: packet flow log keyed by the five-tuple
// linear-search table with saturating hit counters, indexed read and clear
// ----------------------------------------------------------------------------
//
//  channel | signals                         | meaning of one beat
//  --------+---------------------------------+-------------------------------
//  s_      | s_valid/s_ready + 10 fields     | log, read or clear command
//  m_      | m_valid/m_ready + 11 fields     | one result per command
//
// scan: a log beat scans the valid entries through the single read port
// of the entry memory, one entry per cycle, and compares each one in the
// shared key comparator; a hit then writes the entry back with its count
// raised and a miss appends the key unless the table is full. s_ready
// returns in the same cycle that m_valid rises.
// reset: only the entry count and control state clear; the memory keeps
// stale data that is never read because only entries below the count are.
// stalls: s_ready is high only while the sequencer is idle; a result waits
// in the output register, and the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module five_tuple_flow_log_table_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [31:0]        s_pkt_time,
    input  wire logic [7:0]         s_proto_num,
    input  wire logic [7:0]         s_verdict,
    input  wire logic [31:0]        s_source_addr,
    input  wire logic [31:0]        s_dest_addr,
    input  wire logic [15:0]        s_source_port_in,
    input  wire logic [15:0]        s_dest_port_in,
    input  wire logic signed [31:0] s_cause_code,
    input  wire logic [7:0]         s_read_index,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [8:0]              m_entries_used,
    output logic [31:0]             m_out_time,
    output logic [7:0]              m_out_proto,
    output logic [7:0]              m_out_verdict,
    output logic [31:0]             m_out_source_addr,
    output logic [31:0]             m_out_dest_addr,
    output logic [15:0]             m_out_source_port,
    output logic [15:0]             m_out_dest_port,
    output logic signed [31:0]      m_out_cause,
    output logic [31:0]             m_out_hits
);

    localparam int IDX_W  = ftfl_pkg::IDX_W;
    localparam int CNT_W  = ftfl_pkg::CNT_W;
    localparam int WIDE_W = ftfl_pkg::WIDE_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ftfl_pkg::LOG_DEPTH);

    // entry memory: one write port, one registered read port
    ftfl_pkg::entry_t mem [ftfl_pkg::LOG_DEPTH];

    ftfl_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;     // next entry to fetch
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next; // entry held in rd_data_reg
    logic              cmp_valid_reg, cmp_valid_next;
    ftfl_pkg::status_t status_reg, status_next;

    // captured command
    ftfl_pkg::entry_t  cmd_reg, cmd_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;

    // memory ports
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    ftfl_pkg::entry_t  rd_data_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ftfl_pkg::entry_t  wr_data;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              out_load;
    ftfl_pkg::status_t m_status_reg;
    logic [8:0]        m_used_reg;
    ftfl_pkg::entry_t  m_entry_reg;

    logic              accept;
    logic              key_match;
    logic              more_to_scan;
    logic              read_in_range;
    logic [31:0]       hits_inc;

    assign s_ready       = (state_reg == ftfl_pkg::S_IDLE);
    assign accept        = s_valid && s_ready;
    assign more_to_scan  = issue_reg < total_reg;
    assign read_in_range = WIDE_W'(s_read_index) < WIDE_W'(total_reg);

    // the shared comparator: stored five-tuple against the captured key
    assign key_match = (rd_data_reg.src_addr == cmd_reg.src_addr)
                    && (rd_data_reg.dst_addr == cmd_reg.dst_addr)
                    && (rd_data_reg.ports    == cmd_reg.ports)
                    && (rd_data_reg.proto    == cmd_reg.proto);

    // saturating count
    assign hits_inc = (rd_data_reg.hits == 32'hFFFF_FFFF) ? rd_data_reg.hits
                                                          : rd_data_reg.hits + 32'd1;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ftfl_pkg::S_IDLE: begin
                if (accept) begin
                    case (ftfl_pkg::op_t'(s_operation))
                        ftfl_pkg::OP_LOG:  state_next = ftfl_pkg::S_SCAN;
                        ftfl_pkg::OP_READ: state_next = ftfl_pkg::S_READ;
                        default:           state_next = ftfl_pkg::S_DONE;
                    endcase
                end
            end
            ftfl_pkg::S_SCAN: begin
                if (cmp_valid_reg && key_match) begin
                    state_next = ftfl_pkg::S_HIT_WR;
                end else if (!more_to_scan && !cmp_valid_reg) begin
                    state_next = ftfl_pkg::S_DONE;
                end
            end
            ftfl_pkg::S_HIT_WR: state_next = ftfl_pkg::S_DONE;
            ftfl_pkg::S_READ:   state_next = ftfl_pkg::S_DONE;
            ftfl_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ftfl_pkg::S_IDLE;
                end
            end
            default: state_next = ftfl_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs and datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        total_next     = total_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        status_next    = status_reg;
        cmd_next       = cmd_reg;
        ridx_next      = ridx_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = total_reg[IDX_W-1:0];
        wr_data        = cmd_reg;
        out_load       = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ftfl_pkg::S_IDLE: begin
                if (accept) begin
                    cmd_next.src_addr = s_source_addr;
                    cmd_next.dst_addr = s_dest_addr;
                    cmd_next.ports    = {s_source_port_in, s_dest_port_in};
                    cmd_next.proto    = s_proto_num;
                    cmd_next.verdict  = s_verdict;
                    cmd_next.cause    = s_cause_code;
                    cmd_next.stamp    = s_pkt_time;
                    cmd_next.hits     = 32'd1;
                    ridx_next         = IDX_W'(s_read_index);
                    issue_next        = '0;
                    cmp_valid_next    = 1'b0;
                    case (ftfl_pkg::op_t'(s_operation))
                        ftfl_pkg::OP_LOG: begin
                        end
                        ftfl_pkg::OP_READ: begin
                            status_next = read_in_range ? ftfl_pkg::ST_READ_OK
                                                        : ftfl_pkg::ST_READ_OOR;
                        end
                        default: begin
                            // the spare code clears as well
                            total_next  = '0;
                            status_next = ftfl_pkg::ST_CLEARED;
                        end
                    endcase
                end
            end
            ftfl_pkg::S_SCAN: begin
                if (cmp_valid_reg && key_match) begin
                    cmp_valid_next = 1'b0;
                end else if (more_to_scan) begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end else if (cmp_valid_reg) begin
                    cmp_valid_next = 1'b0;
                end else if (total_reg == DEPTH_CNT) begin
                    status_next = ftfl_pkg::ST_FULL;
                end else begin
                    // miss: append at the end of the table
                    wr_en       = 1'b1;
                    total_next  = total_reg + CNT_W'(1);
                    status_next = ftfl_pkg::ST_INSERTED;
                end
            end
            ftfl_pkg::S_HIT_WR: begin
                wr_en         = 1'b1;
                wr_addr       = cmp_idx_reg;
                wr_data       = rd_data_reg;
                wr_data.hits  = hits_inc;
                wr_data.stamp = cmd_reg.stamp;
                status_next   = ftfl_pkg::ST_HIT;
            end
            ftfl_pkg::S_READ: begin
                rd_en   = 1'b1;
                rd_addr = ridx_reg;
            end
            ftfl_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ftfl_pkg::S_IDLE;
            total_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        status_reg  <= status_next;
        cmd_reg     <= cmd_next;
        ridx_reg    <= ridx_next;
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output register; entry fields only carry data on a good read
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_reg;
            m_used_reg   <= 9'(total_reg);
            m_entry_reg  <= (status_reg == ftfl_pkg::ST_READ_OK) ? rd_data_reg : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_entries_used    = m_used_reg;
    assign m_out_time        = m_entry_reg.stamp;
    assign m_out_proto       = m_entry_reg.proto;
    assign m_out_verdict     = m_entry_reg.verdict;
    assign m_out_source_addr = m_entry_reg.src_addr;
    assign m_out_dest_addr   = m_entry_reg.dst_addr;
    assign m_out_source_port = m_entry_reg.ports[31:16];
    assign m_out_dest_port   = m_entry_reg.ports[15:0];
    assign m_out_cause       = m_entry_reg.cause;
    assign m_out_hits        = m_entry_reg.hits;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg != $past(total_reg)) |->
            (total_reg == '0) || (total_reg == $past(total_reg) + CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_wr_when: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ftfl_pkg::S_SCAN) || (state_reg == ftfl_pkg::S_HIT_WR))
        else $error("memory write outside scan or hit update");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_reg == ftfl_pkg::ST_FULL) |-> (total_reg == DEPTH_CNT))
        else $error("full reported with free entries");

    a_hit_after_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ftfl_pkg::S_HIT_WR) |-> $past(cmp_valid_reg && key_match))
        else $error("hit update without a match");

endmodule
`default_nettype wire

>>> test/five_tuple_flow_log_table_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// five_tuple_flow_log_table_core_tb: self-checking bench for the flow log table
// a queue-fed driver offers log, read and clear beats with random gaps, a
// monitor predicts each result from its own copy of the table and checks every
// result beat field by field; the receiver stalls at random and once for long
// ----------------------------------------------------------------------------
module five_tuple_flow_log_table_core_tb;

    localparam int CLK_PERIOD = 8;
    localparam int LONG_HOLD  = 400;

    // which key field a near-miss flow differs in
    typedef enum int {
        KEY_SRC,
        KEY_DST,
        KEY_SPORT,
        KEY_DPORT,
        KEY_PROTO
    } key_field_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_tuple_t;

    typedef struct packed {
        ftfl_pkg::op_t      op;
        logic [31:0]        stamp;
        logic [7:0]         proto;
        logic [7:0]         verdict;
        logic [31:0]        src;
        logic [31:0]        dst;
        logic [15:0]        sport;
        logic [15:0]        dport;
        logic signed [31:0] cause;
        logic [7:0]         rd_index;
    } flow_cmd_t;

    typedef struct packed {
        ftfl_pkg::status_t  status;
        logic [8:0]         used;
        logic [31:0]        stamp;
        logic [7:0]         proto;
        logic [7:0]         verdict;
        logic [31:0]        src;
        logic [31:0]        dst;
        logic [15:0]        sport;
        logic [15:0]        dport;
        logic signed [31:0] cause;
        logic [31:0]        hits;
    } flow_result_t;

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation       = '0;
    logic [31:0]        s_pkt_time        = '0;
    logic [7:0]         s_proto_num       = '0;
    logic [7:0]         s_verdict         = '0;
    logic [31:0]        s_source_addr     = '0;
    logic [31:0]        s_dest_addr       = '0;
    logic [15:0]        s_source_port_in  = '0;
    logic [15:0]        s_dest_port_in    = '0;
    logic signed [31:0] s_cause_code      = '0;
    logic [7:0]         s_read_index      = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [2:0]         m_status;
    logic [8:0]         m_entries_used;
    logic [31:0]        m_out_time;
    logic [7:0]         m_out_proto;
    logic [7:0]         m_out_verdict;
    logic [31:0]        m_out_source_addr;
    logic [31:0]        m_out_dest_addr;
    logic [15:0]        m_out_source_port;
    logic [15:0]        m_out_dest_port;
    logic signed [31:0] m_out_cause;
    logic [31:0]        m_out_hits;

    // bench copy of the table
    ftfl_pkg::entry_t flow_tab [ftfl_pkg::LOG_DEPTH];
    int               flow_count = 0;

    flow_cmd_t    cmd_q [$];          // beats still to be offered
    flow_result_t result_expect_q [$];
    flow_cmd_t    offered;            // beat currently on the input channel
    bit           beat_taken = 1'b0;  // set at the edge that accepts it
    int           send_gap   = 0;
    int           send_calm  = 0;
    int           stall_left = 0;
    int           recv_calm  = 0;
    int           hold_left  = 0;
    bit           hold_done  = 1'b0;
    int           results_seen = 0;
    int           error_count  = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    five_tuple_flow_log_table_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_pkt_time        (s_pkt_time),
        .s_proto_num       (s_proto_num),
        .s_verdict         (s_verdict),
        .s_source_addr     (s_source_addr),
        .s_dest_addr       (s_dest_addr),
        .s_source_port_in  (s_source_port_in),
        .s_dest_port_in    (s_dest_port_in),
        .s_cause_code      (s_cause_code),
        .s_read_index      (s_read_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_entries_used    (m_entries_used),
        .m_out_time        (m_out_time),
        .m_out_proto       (m_out_proto),
        .m_out_verdict     (m_out_verdict),
        .m_out_source_addr (m_out_source_addr),
        .m_out_dest_addr   (m_out_dest_addr),
        .m_out_source_port (m_out_source_port),
        .m_out_dest_port   (m_out_dest_port),
        .m_out_cause       (m_out_cause),
        .m_out_hits        (m_out_hits)
    );

    // ------------------------------------------------------------------
    // table prediction: one command beat in, the result it must produce
    // ------------------------------------------------------------------
    function automatic flow_result_t flow_table_step(flow_cmd_t c);
        flow_result_t r;
        logic [31:0]  ports;
        int           hit_at;
        r      = '0;
        ports  = {c.sport, c.dport};
        hit_at = -1;
        case (c.op)
            ftfl_pkg::OP_LOG: begin
                // first matching valid entry wins; verdict and cause are not keys
                for (int i = 0; i < flow_count && hit_at < 0; i++) begin
                    if (flow_tab[i].src_addr == c.src && flow_tab[i].dst_addr == c.dst &&
                        flow_tab[i].ports == ports && flow_tab[i].proto == c.proto)
                        hit_at = i;
                end
                if (hit_at >= 0) begin
                    if (flow_tab[hit_at].hits != 32'hFFFF_FFFF)
                        flow_tab[hit_at].hits = flow_tab[hit_at].hits + 1;
                    flow_tab[hit_at].stamp = c.stamp;
                    r.status = ftfl_pkg::ST_HIT;
                end else if (flow_count >= ftfl_pkg::LOG_DEPTH) begin
                    r.status = ftfl_pkg::ST_FULL;
                end else begin
                    flow_tab[flow_count].src_addr = c.src;
                    flow_tab[flow_count].dst_addr = c.dst;
                    flow_tab[flow_count].ports    = ports;
                    flow_tab[flow_count].proto    = c.proto;
                    flow_tab[flow_count].verdict  = c.verdict;
                    flow_tab[flow_count].cause    = c.cause;
                    flow_tab[flow_count].stamp    = c.stamp;
                    flow_tab[flow_count].hits     = 32'd1;
                    flow_count++;
                    r.status = ftfl_pkg::ST_INSERTED;
                end
            end
            ftfl_pkg::OP_READ: begin
                if (int'(c.rd_index) < flow_count) begin
                    r.status  = ftfl_pkg::ST_READ_OK;
                    r.stamp   = flow_tab[c.rd_index].stamp;
                    r.proto   = flow_tab[c.rd_index].proto;
                    r.verdict = flow_tab[c.rd_index].verdict;
                    r.src     = flow_tab[c.rd_index].src_addr;
                    r.dst     = flow_tab[c.rd_index].dst_addr;
                    r.sport   = flow_tab[c.rd_index].ports[31:16];
                    r.dport   = flow_tab[c.rd_index].ports[15:0];
                    r.cause   = flow_tab[c.rd_index].cause;
                    r.hits    = flow_tab[c.rd_index].hits;
                end else begin
                    r.status = ftfl_pkg::ST_READ_OOR;
                end
            end
            default: begin
                // clear and the spare code both just drop the count
                flow_count = 0;
                r.status   = ftfl_pkg::ST_CLEARED;
            end
        endcase
        r.used = 9'(flow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 64);
    endfunction

    // every field random, the op fixed
    function automatic flow_cmd_t noise_cmd(ftfl_pkg::op_t op);
        flow_cmd_t c;
        c.op       = op;
        c.stamp    = $urandom;
        c.proto    = 8'($urandom);
        c.verdict  = 8'($urandom);
        c.src      = $urandom;
        c.dst      = $urandom;
        c.sport    = 16'($urandom);
        c.dport    = 16'($urandom);
        c.cause    = $signed($urandom);
        c.rd_index = 8'($urandom);
        return c;
    endfunction

    function automatic flow_cmd_t log_cmd(flow_tuple_t t);
        flow_cmd_t c;
        c       = noise_cmd(ftfl_pkg::OP_LOG);
        c.src   = t.src;
        c.dst   = t.dst;
        c.sport = t.sport;
        c.dport = t.dport;
        c.proto = t.proto;
        return c;
    endfunction

    function automatic flow_cmd_t read_cmd(int unsigned idx);
        flow_cmd_t c;
        c          = noise_cmd(ftfl_pkg::OP_READ);
        c.rd_index = 8'(idx);
        return c;
    endfunction

    function automatic flow_tuple_t fresh_tuple();
        flow_tuple_t t;
        t.src   = $urandom;
        t.dst   = $urandom;
        t.sport = 16'($urandom);
        t.dport = 16'($urandom);
        t.proto = 8'($urandom);
        return t;
    endfunction

    // same flow but one bit off in one key field
    function automatic flow_tuple_t tweak(flow_tuple_t t, key_field_t which);
        int unsigned pos;
        pos = $urandom_range(0, 31);
        case (which)
            KEY_SRC:   t.src[pos]        = ~t.src[pos];
            KEY_DST:   t.dst[pos]        = ~t.dst[pos];
            KEY_SPORT: t.sport[pos % 16] = ~t.sport[pos % 16];
            KEY_DPORT: t.dport[pos % 16] = ~t.dport[pos % 16];
            default:   t.proto[pos % 8]  = ~t.proto[pos % 8];
        endcase
        return t;
    endfunction

    task automatic report_error(string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic compare_field(string fname, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h want %h", fname, got, want));
    endtask

    // ------------------------------------------------------------------
    // driver: next beat goes out at the falling edge after a random gap
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        bit next_valid;
        next_valid = s_valid;
        if (beat_taken) begin
            beat_taken = 1'b0;
            next_valid = 1'b0;
        end
        if (aresetn && !next_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (cmd_q.size() != 0) begin
                offered = cmd_q.pop_front();
                s_operation      <= offered.op;
                s_pkt_time       <= offered.stamp;
                s_proto_num      <= offered.proto;
                s_verdict        <= offered.verdict;
                s_source_addr    <= offered.src;
                s_dest_addr      <= offered.dst;
                s_source_port_in <= offered.sport;
                s_dest_port_in   <= offered.dport;
                s_cause_code     <= offered.cause;
                s_read_index     <= offered.rd_index;
                next_valid = 1'b1;
                send_gap   = pick_gap(send_calm);
            end
        end
        s_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off that backs up the
    // block so its input stalls while beats keep being offered
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 120) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap(recv_calm);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check result beats, then predict from accepted command beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        flow_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (result_expect_q.size() == 0) begin
                    report_error("result beat with no command outstanding");
                end else begin
                    want = result_expect_q.pop_front();
                    compare_field("status", 32'(m_status), 32'(want.status));
                    compare_field("entries_used", 32'(m_entries_used), 32'(want.used));
                    compare_field("out_time", m_out_time, want.stamp);
                    compare_field("out_proto", 32'(m_out_proto), 32'(want.proto));
                    compare_field("out_verdict", 32'(m_out_verdict), 32'(want.verdict));
                    compare_field("out_source_addr", m_out_source_addr, want.src);
                    compare_field("out_dest_addr", m_out_dest_addr, want.dst);
                    compare_field("out_source_port", 32'(m_out_source_port),
                                  32'(want.sport));
                    compare_field("out_dest_port", 32'(m_out_dest_port), 32'(want.dport));
                    compare_field("out_cause", m_out_cause, want.cause);
                    compare_field("out_hits", m_out_hits, want.hits);
                end
            end
            if (s_valid && s_ready) begin
                beat_taken = 1'b1;
                result_expect_q.push_back(flow_table_step(offered));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        flow_tuple_t zeros;
        flow_tuple_t ones;
        flow_tuple_t t;
        flow_tuple_t flow_pool [$];
        flow_cmd_t   c;
        int          roll;

        zeros = '0;
        ones  = '1;

        // directed: empty table, extremes, each key field, bounds, both clears
        cmd_q.push_back(noise_cmd(ftfl_pkg::OP_CLEAR));
        cmd_q.push_back(read_cmd(0));
        c = log_cmd(zeros);
        c.stamp = '0; c.verdict = '0; c.cause = 32'sh8000_0000; c.rd_index = '0;
        cmd_q.push_back(c);
        c = log_cmd(ones);
        c.stamp = '1; c.verdict = '1; c.cause = 32'sh7FFF_FFFF; c.rd_index = '1;
        cmd_q.push_back(c);
        // hit must keep the stored verdict and cause
        c = log_cmd(zeros);
        c.verdict = '1; c.cause = -1;
        cmd_q.push_back(c);
        cmd_q.push_back(log_cmd(tweak(ones, KEY_SRC)));
        cmd_q.push_back(log_cmd(tweak(ones, KEY_DST)));
        cmd_q.push_back(log_cmd(tweak(ones, KEY_SPORT)));
        cmd_q.push_back(log_cmd(tweak(ones, KEY_DPORT)));
        cmd_q.push_back(log_cmd(tweak(ones, KEY_PROTO)));
        cmd_q.push_back(log_cmd(ones));
        cmd_q.push_back(read_cmd(0));
        cmd_q.push_back(read_cmd(1));
        cmd_q.push_back(read_cmd(6));
        cmd_q.push_back(read_cmd(7));      // first index past the end
        cmd_q.push_back(read_cmd(255));
        cmd_q.push_back(noise_cmd(ftfl_pkg::OP_ALT));
        cmd_q.push_back(read_cmd(0));      // stale data is no longer readable
        cmd_q.push_back(log_cmd(ones));
        cmd_q.push_back(read_cmd(0));
        cmd_q.push_back(noise_cmd(ftfl_pkg::OP_CLEAR));

        // fill past capacity with no clears, so the full case is reached
        repeat (340) begin
            roll = $urandom_range(0, 99);
            if (roll < 80 || flow_pool.size() == 0) begin
                t = fresh_tuple();
                flow_pool.push_back(t);
                cmd_q.push_back(log_cmd(t));
            end else if (roll < 92) begin
                cmd_q.push_back(log_cmd(flow_pool[$urandom_range(0, flow_pool.size() - 1)]));
            end else begin
                cmd_q.push_back(read_cmd($urandom_range(0, 255)));
            end
        end
        // table is full now: new flows drop, known ones still count
        repeat (30) begin
            roll = $urandom_range(0, 2);
            if (roll == 0)
                cmd_q.push_back(log_cmd(fresh_tuple()));
            else if (roll == 1)
                cmd_q.push_back(log_cmd(flow_pool[$urandom_range(0, flow_pool.size() - 1)]));
            else
                cmd_q.push_back(read_cmd($urandom_range(0, 255)));
        end
        cmd_q.push_back(noise_cmd(ftfl_pkg::OP_CLEAR));

        // mixed traffic over a small set of recurring flows
        flow_pool.delete();
        repeat (510) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd_q.push_back(noise_cmd($urandom_range(0, 1) ? ftfl_pkg::OP_CLEAR
                                                               : ftfl_pkg::OP_ALT));
            end else if (roll < 25) begin
                if ($urandom_range(0, 3) == 0)
                    cmd_q.push_back(read_cmd($urandom_range(0, 255)));
                else
                    cmd_q.push_back(read_cmd($urandom_range(0, 24)));
            end else if (roll < 45 || flow_pool.size() == 0) begin
                t = fresh_tuple();
                if (flow_pool.size() >= 48)
                    flow_pool[$urandom_range(0, 47)] = t;
                else
                    flow_pool.push_back(t);
                cmd_q.push_back(log_cmd(t));
            end else if (roll < 85) begin
                cmd_q.push_back(log_cmd(flow_pool[$urandom_range(0, flow_pool.size() - 1)]));
            end else begin
                t = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                cmd_q.push_back(log_cmd(tweak(t, key_field_t'($urandom_range(0, 4)))));
            end
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_valid || result_expect_q.size() != 0)
            @(posedge aclk);
        // a full scan plus margin, in case a stray result shows up late
        repeat (ftfl_pkg::LOG_DEPTH + 16) @(posedge aclk);
        if (error_count == 0)
            $display("[five_tuple_flow_log_table_core] OK");
        else
            $display("[five_tuple_flow_log_table_core] ERROR");
        $finish;
    end

    // run limit: worst-case scans, longest gaps and stalls, several times over
    initial begin
        #(CLK_PERIOD * 1_500_000);
        $display("[five_tuple_flow_log_table_core] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

>>> files.f
src/ftfl_pkg.sv
src/five_tuple_flow_log_table_core.sv
test/five_tuple_flow_log_table_core_tb.sv
